/* rtl/core/tfr_pkg.sv */
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants of the telemetry frame receiver: frame layout,
// status codes, register map and the structs passed between modules.
// ----------------------------------------------------------------------------
package tfr_pkg;

   localparam int unsigned BYTE_WIDTH     = 8;
   localparam int unsigned POS_WIDTH      = 5;
   localparam int unsigned SUM_WIDTH      = 12;
   localparam int unsigned STORE_DEPTH    = 23;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [POS_WIDTH-1:0] POS_FIRST      = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_LAST       = 5'd24;
   localparam logic [POS_WIDTH-1:0] POS_SUM_END    = 5'd12;
   localparam logic [POS_WIDTH-1:0] POS_REF_LOW    = 5'd17;
   localparam logic [POS_WIDTH-1:0] POS_REF_HIGH   = 5'd18;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_GOOD = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic REG_START_BYTE = 1'b0;
   localparam logic REG_END_BYTE   = 1'b1;

   localparam logic [7:0] START_BYTE_RESET = 8'd2;
   localparam logic [7:0] END_BYTE_RESET   = 8'd3;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         frame_status;
      logic [31:0]        duration;
      logic [15:0]        rpm;
      logic [15:0]        current_value;
      logic [15:0]        voltage_value;
      logic [15:0]        temperature;
      logic [31:0]        ref_time;
      logic signed [15:0] reference_value;
      logic [7:0]         frame_code;
   } result_type;

endpackage

/* rtl/core/tfr_csr.sv */
// ----------------------------------------------------------------------------
// tfr_csr
// Register block for the start and end byte values, with an APB-style
// write and read port.
// ----------------------------------------------------------------------------
module tfr_csr
   import tfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_START_BYTE: cfg_in.start_byte = pwdata[7:0];
            REG_END_BYTE:   cfg_in.end_byte   = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_START_BYTE: prdata = {24'd0, cfg_ff.start_byte};
         REG_END_BYTE:   prdata = {24'd0, cfg_ff.end_byte};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= START_BYTE_RESET;
         cfg_ff.end_byte   <= END_BYTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/tfr_decoder.sv */
// ----------------------------------------------------------------------------
// tfr_decoder
// Frame state, byte store and running checksum. On each step it takes one
// byte and forms the result item for that byte.
// ----------------------------------------------------------------------------
module tfr_decoder
   import tfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output result_type result
);

   logic                 collecting_ff;
   logic                 collecting_in;
   logic [POS_WIDTH-1:0] position_ff;
   logic [POS_WIDTH-1:0] position_in;
   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SUM_WIDTH-1:0] sum_in;
   logic [7:0]           store_ff [STORE_DEPTH];

   logic                 in_body;
   logic                 summed;
   logic [POS_WIDTH-1:0] store_idx;
   logic [31:0]          checksum;
   logic                 frame_ok;

   assign in_body   = (position_ff >= POS_FIRST) && (position_ff < POS_LAST);
   assign summed    = (position_ff <= POS_SUM_END) || (position_ff == POS_REF_LOW)
                      || (position_ff == POS_REF_HIGH);
   assign store_idx = position_ff - POS_FIRST;
   assign checksum  = {store_ff[21], store_ff[20], store_ff[19], store_ff[18]};
   assign frame_ok  = (rx_byte == cfg.end_byte)
                      && (checksum == {{(32-SUM_WIDTH){1'b0}}, sum_ff});

   always_comb begin
      collecting_in = collecting_ff;
      position_in   = position_ff;
      sum_in        = sum_ff;
      result        = '0;
      result.frame_status = STATUS_NONE;
      if (!collecting_ff) begin
         if (rx_byte == cfg.start_byte) begin
            collecting_in = 1'b1;
            position_in   = POS_FIRST;
            sum_in        = '0;
         end
      end else if (in_body) begin
         if (summed) begin
            sum_in = sum_ff + {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, rx_byte};
         end
         position_in = position_ff + POS_FIRST;
      end else begin
         collecting_in = 1'b0;
         position_in   = '0;
         sum_in        = '0;
         if (frame_ok) begin
            result.frame_status    = STATUS_GOOD;
            result.duration        = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
            result.rpm             = {store_ff[5], store_ff[4]};
            result.current_value   = {store_ff[7], store_ff[6]};
            result.voltage_value   = {store_ff[9], store_ff[8]};
            result.temperature     = {store_ff[11], store_ff[10]};
            result.ref_time        = {store_ff[15], store_ff[14], store_ff[13],
                                      store_ff[12]};
            result.reference_value = {store_ff[17], store_ff[16]};
            result.frame_code      = store_ff[22];
         end else begin
            result.frame_status = STATUS_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         position_ff   <= '0;
         sum_ff        <= '0;
      end else if (step) begin
         collecting_ff <= collecting_in;
         position_ff   <= position_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && collecting_ff && in_body) begin
         store_ff[store_idx] <= rx_byte;
      end
   end

endmodule

/* rtl/core/telemetry_frame_receiver.sv */
// ----------------------------------------------------------------------------
// telemetry_frame_receiver
// Byte-serial receiver for a fixed 25-byte telemetry frame with an additive
// checksum. Every received byte yields one result item.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Direction   Carries
//  req       req_valid/req_ready        in          one received byte
//  rsp       rsp_valid/rsp_ready        out         frame status and fields
//  csr       psel..pready               in/out      start and end byte values
//
// One item per cycle is accepted while the result channel is not stalled. A
// byte is captured in the input register and then decoded into the result
// register, from which its result is offered.
// The input register refills while a result waits, and a stalled result holds
// both stages.
// Reset is synchronous and clears the frame state and the handshake stages.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver
   import tfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_frame_status,
   output logic [31:0]               rsp_duration,
   output logic [15:0]               rsp_rpm,
   output logic [15:0]               rsp_current_value,
   output logic [15:0]               rsp_voltage_value,
   output logic [15:0]               rsp_temperature,
   output logic [31:0]               rsp_ref_time,
   output logic signed [15:0]        rsp_reference_value,
   output logic [7:0]                rsp_frame_code,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type    cfg;
   result_type result;
   result_type result_ff;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       advance;

   tfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tfr_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_frame_status    = result_ff.frame_status;
   assign rsp_duration        = result_ff.duration;
   assign rsp_rpm             = result_ff.rpm;
   assign rsp_current_value   = result_ff.current_value;
   assign rsp_voltage_value   = result_ff.voltage_value;
   assign rsp_temperature     = result_ff.temperature;
   assign rsp_ref_time        = result_ff.ref_time;
   assign rsp_reference_value = result_ff.reference_value;
   assign rsp_frame_code      = result_ff.frame_code;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for telemetry_frame_receiver. It drives received
// bytes over the request channel and programs the start and end byte values
// through the register port. A predictor tracks the frame collection state
// and works out the result item for every accepted byte. The checker
// compares each result field by field. Directed frames come first, followed
// by random traffic under several idling and stall mixes.
// ----------------------------------------------------------------------------
module tb;
   import tfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 500;

   typedef logic [24:0][7:0] frame_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_rx_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [1:0]                rsp_frame_status;
   logic [31:0]               rsp_duration;
   logic [15:0]               rsp_rpm;
   logic [15:0]               rsp_current_value;
   logic [15:0]               rsp_voltage_value;
   logic [15:0]               rsp_temperature;
   logic [31:0]               rsp_ref_time;
   logic signed [15:0]        rsp_reference_value;
   logic [7:0]                rsp_frame_code;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   logic [7:0]  cfg_start;
   logic [7:0]  cfg_end;
   logic        rx_collecting;
   logic [4:0]  rx_pos;
   logic [11:0] rx_sum;
   logic [7:0]  rx_store [1:23];

   result_type result_due [$];
   int error_count;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;

   telemetry_frame_receiver dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_duration        (rsp_duration),
      .rsp_rpm             (rsp_rpm),
      .rsp_current_value   (rsp_current_value),
      .rsp_voltage_value   (rsp_voltage_value),
      .rsp_temperature     (rsp_temperature),
      .rsp_ref_time        (rsp_ref_time),
      .rsp_reference_value (rsp_reference_value),
      .rsp_frame_code      (rsp_frame_code),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic result_type decode_rx_byte(input logic [7:0] b);
      result_type  r;
      logic [31:0] received_sum;
      r = '0;
      r.frame_status = STATUS_NONE;
      if (!rx_collecting) begin
         if (b == cfg_start) begin
            rx_collecting = 1'b1;
            rx_pos = POS_FIRST;
            rx_sum = '0;
         end
      end else if (rx_pos < POS_LAST) begin
         rx_store[rx_pos] = b;
         if (rx_pos <= POS_SUM_END || rx_pos == POS_REF_LOW || rx_pos == POS_REF_HIGH)
            rx_sum = rx_sum + b;
         rx_pos = rx_pos + 5'd1;
      end else begin
         received_sum = {rx_store[22], rx_store[21], rx_store[20], rx_store[19]};
         if (b == cfg_end && received_sum == {20'd0, rx_sum}) begin
            r.frame_status    = STATUS_GOOD;
            r.duration        = {rx_store[4], rx_store[3], rx_store[2], rx_store[1]};
            r.rpm             = {rx_store[6], rx_store[5]};
            r.current_value   = {rx_store[8], rx_store[7]};
            r.voltage_value   = {rx_store[10], rx_store[9]};
            r.temperature     = {rx_store[12], rx_store[11]};
            r.ref_time        = {rx_store[16], rx_store[15], rx_store[14], rx_store[13]};
            r.reference_value = {rx_store[18], rx_store[17]};
            r.frame_code      = rx_store[23];
         end else begin
            r.frame_status = STATUS_BAD;
         end
         rx_collecting = 1'b0;
         rx_pos = '0;
         rx_sum = '0;
      end
      return r;
   endfunction

   function automatic frame_type seal_frame(input frame_type f);
      logic [11:0] sum;
      sum = '0;
      for (int p = 1; p <= POS_REF_HIGH; p++)
         if (p <= POS_SUM_END || p >= POS_REF_LOW)
            sum = sum + f[p];
      f[0] = cfg_start;
      {f[22], f[21], f[20], f[19]} = {20'd0, sum};
      f[24] = cfg_end;
      return f;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_due.size() == 0) begin
            $error("frame_status: expected no item, actual %0h", rsp_frame_status);
            error_count++;
         end else begin
            want = result_due.pop_front();
            check_field("frame_status", 32'(want.frame_status), 32'(rsp_frame_status));
            check_field("duration", want.duration, rsp_duration);
            check_field("rpm", 32'(want.rpm), 32'(rsp_rpm));
            check_field("current_value", 32'(want.current_value),
                        32'(rsp_current_value));
            check_field("voltage_value", 32'(want.voltage_value),
                        32'(rsp_voltage_value));
            check_field("temperature", 32'(want.temperature), 32'(rsp_temperature));
            check_field("ref_time", want.ref_time, rsp_ref_time);
            check_field("reference_value", 32'(want.reference_value),
                        32'(rsp_reference_value));
            check_field("frame_code", 32'(want.frame_code), 32'(rsp_frame_code));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      result_type due;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = decode_rx_byte(b);
      result_due = {result_due, due};
      @(negedge clock);
   endtask

   task automatic send_frame(input frame_type f, input int len);
      for (int i = 0; i < len; i++)
         send_byte(f[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (result_due.size() != 0);
   endtask

   task automatic csr_access(input logic reg_idx, input logic is_write,
                             input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= CSR_ADDR_WIDTH'({reg_idx, 2'b00});
      pwdata <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (!is_write)
         check_field(reg_idx == REG_START_BYTE ? "start_byte" : "end_byte",
                     {24'd0, value}, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] start_value, input logic [7:0] end_value);
      wait_drained();
      repeat (3) @(negedge clock);
      csr_access(REG_START_BYTE, 1'b1, start_value);
      csr_access(REG_END_BYTE, 1'b1, end_value);
      cfg_start = start_value;
      cfg_end = end_value;
      csr_access(REG_START_BYTE, 1'b0, start_value);
      csr_access(REG_END_BYTE, 1'b0, end_value);
   endtask

   function automatic frame_type random_frame();
      frame_type f;
      for (int p = 0; p <= 24; p++)
         f[p] = 8'($urandom_range(255));
      return seal_frame(f);
   endfunction

   task automatic test_default_frames();
      frame_type f;
      wait_drained();
      csr_access(REG_START_BYTE, 1'b0, START_BYTE_RESET);
      csr_access(REG_END_BYTE, 1'b0, END_BYTE_RESET);
      f = seal_frame('0);
      send_frame(f, 25);
      f = seal_frame({25{8'hFF}});
      send_frame(f, 25);
   endtask

   task automatic test_embedded_delimiters();
      frame_type f;
      for (int p = 1; p <= 23; p++)
         f[p] = p[0] ? cfg_end : cfg_start;
      f = seal_frame(f);
      send_frame(f, 25);
   endtask

   task automatic test_bad_closing();
      frame_type f;
      f = random_frame();
      f[24] = cfg_start;
      send_frame(f, 25);
      send_frame(random_frame(), 25);
   endtask

   task automatic test_checksum_mismatch();
      frame_type f;
      f = random_frame();
      f[22] = 8'h01;
      send_frame(f, 25);
      f = random_frame();
      f[19][0] = ~f[19][0];
      send_frame(f, 25);
   endtask

   task automatic test_config_extremes();
      set_config(8'h00, 8'hFF);
      send_frame(random_frame(), 25);
      set_config(8'hFF, 8'h00);
      send_frame(seal_frame({25{8'hFF}}), 25);
      set_config(8'h5A, 8'h5A);
      send_frame(random_frame(), 25);
   endtask

   task automatic test_random_traffic();
      int         sent;
      int         frames;
      int         len;
      frame_type  f;
      logic [7:0] b;
      logic [7:0] start_value;
      logic [7:0] end_value;
      sent = 0;
      frames = 0;
      while (sent < RANDOM_ITEMS) begin
         if (frames % 4 == 0) begin
            start_value = 8'($urandom_range(255));
            end_value = ($urandom_range(3) == 0) ? start_value : 8'($urandom_range(255));
            set_config(start_value, end_value);
            case ((frames / 4) % 4)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 60; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 60; end
               default: begin idle_pct = 34; stall_pct = 34; end
            endcase
         end
         f = random_frame();
         len = 25;
         case ($urandom_range(9))
            6: f[24] = cfg_end ^ 8'($urandom_range(1, 255));
            7: f[19 + $urandom_range(3)][$urandom_range(7)] ^= 1'b1;
            8: len = $urandom_range(1, 24);
            9: begin
               len = 0;
               repeat ($urandom_range(1, 6)) begin
                  b = 8'($urandom_range(255));
                  if (b == cfg_start)
                     b = ~b;
                  send_byte(b);
               end
            end
            default: ;
         endcase
         send_frame(f, len);
         sent += len;
         frames++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_start = START_BYTE_RESET;
      cfg_end = END_BYTE_RESET;
      rx_collecting = 1'b0;
      rx_pos = '0;
      rx_sum = '0;
      error_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_frames();
      test_embedded_delimiters();
      test_bad_closing();
      test_checksum_mismatch();
      test_config_extremes();
      test_random_traffic();

      wait_drained();
      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tfr_pkg.sv
rtl/core/tfr_csr.sv
rtl/core/tfr_decoder.sv
rtl/core/telemetry_frame_receiver.sv
tb/tb.sv
